// ===== sv/dhbd_pkg.sv =====
// Package for the detection head box decoder: widths, limits, register
// indexes and the configuration record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dhbd_pkg;

  // Sizing of the argmax and the prediction index.
  localparam int MAX_CLASSES     = 128;
  localparam int MAX_PREDICTIONS = 16384;
  localparam int CLS_W           = $clog2(MAX_CLASSES);
  localparam int PRED_W          = $clog2(MAX_PREDICTIONS);

  // Field widths.
  localparam int COORD_W    = 16;
  localparam int SCORE_W    = 16;
  localparam int FRAME_W    = 13;
  localparam int PAD_W      = 11;
  localparam int INV_W      = 20;
  localparam int CLASS_ID_W = 7;
  localparam int PRED_ID_W  = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int IN_DATA_W  = 4 * COORD_W + SCORE_W;
  localparam int OUT_BITS   = PRED_ID_W + CLASS_ID_W + SCORE_W + 4 * FRAME_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Edge in 1/32 pixel: 2*center +/- size - 32*pad fits 19 signed bits.
  localparam int EDGE_W     = 19;
  // Edge times the unsigned Q4.16 scale (zero-extended by one bit to make it signed).
  localparam int PROD_W     = EDGE_W + INV_W + 1;
  localparam int FRAC_SHIFT = 21;
  localparam int WHOLE_W    = PROD_W - FRAC_SHIFT;

  // Request kinds carried on tuser.
  localparam logic CMD_BOX   = 1'b0;
  localparam logic CMD_SCORE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_FRAME_WIDTH     = 3'd1,
    REG_FRAME_HEIGHT    = 3'd2,
    REG_PAD_X           = 3'd3,
    REG_PAD_Y           = 3'd4,
    REG_INVERSE_SCALE   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score_threshold;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
    logic [PAD_W-1:0]   pad_x;
    logic [PAD_W-1:0]   pad_y;
    logic [INV_W-1:0]   inverse_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    score_threshold: SCORE_W'(16384),
    frame_width:     FRAME_W'(1920),
    frame_height:    FRAME_W'(1080),
    pad_x:           PAD_W'(0),
    pad_y:           PAD_W'(140),
    inverse_scale:   INV_W'(196608)
  };

endpackage

`default_nettype wire

// ===== sv/dhbd_edge.sv =====
// One box edge: registered multiply by the inverse scale, then floor or
// ceiling to whole pixels and clamp to the frame. Depends on dhbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhbd_edge import dhbd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [EDGE_W-1:0] edge_sub,
  input  wire logic [INV_W-1:0]         inv_scale,
  input  wire logic                     round_up,
  input  wire logic [FRAME_W-1:0]       limit,
  output logic [FRAME_W-1:0]            px
);

  localparam logic [PROD_W-1:0] FRAC_MASK = (PROD_W'(1) << FRAC_SHIFT) - PROD_W'(1);

  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [WHOLE_W-1:0] whole;
  logic [WHOLE_W-1:0]        limit_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'($signed(edge_sub) * $signed({1'b0, inv_scale}));
    end
  end

  // Adding all ones below the binary point before the arithmetic shift
  // turns the floor into a ceiling.
  assign rounded   = prod + $signed(round_up ? FRAC_MASK : '0);
  assign whole     = rounded[PROD_W-1:FRAC_SHIFT];
  assign limit_ext = WHOLE_W'(limit);

  always_comb begin
    if (whole[WHOLE_W-1]) begin
      px = '0;
    end else if (whole > $signed(limit_ext)) begin
      px = limit;
    end else begin
      px = whole[FRAME_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/detection_head_box_decode.sv =====
// Detection head box decoder: argmax over class scores, letterbox removal,
// scaling to source pixels and clamping. Depends on dhbd_pkg, dhbd_edge.
// Throughput: one input request per cycle, box and score items alike, while m_tready does not stall the output.
// A result for a flagged score item passes the input register, edge register,
// product register and output register on its way to m_tdata.
// Reset (rst, synchronous): pipeline empty, argmax and held box cleared,
// prediction index zero, configuration registers at their default values.
`timescale 1ns / 1ps
`default_nettype none

module detection_head_box_decode import dhbd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // center_x, center_y, box_w, box_h, class_score
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // cmd
  input  wire logic                  s_tuser,
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // prediction_index, class_id, confidence, box_left, box_top, box_right,
  // box_bottom, zero fill
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  cfg_t cfg;

  // Stage 1: input register.
  logic               v1;
  logic               cmd1;
  logic               last1;
  logic [IN_DATA_W-1:0] data1;

  // Prediction state.
  logic signed [COORD_W-1:0] held_cx, held_cy, held_w, held_h;
  logic [SCORE_W-1:0] best_score;
  logic [CLS_W-1:0]   best_class;
  logic [CLS_W-1:0]   class_counter;
  logic               classes_full;
  logic [PRED_W-1:0]  pred_counter;

  // Stage 2: finished prediction with edges in 1/32 pixel.
  logic               v2;
  logic [SCORE_W-1:0] score2;
  logic [CLS_W-1:0]   class2;
  logic [PRED_W-1:0]  pred2;
  logic signed [EDGE_W-1:0] e_left, e_right, e_top, e_bottom;

  // Stage 3: products live in the edge units.
  logic               v3;
  logic [SCORE_W-1:0] score3;
  logic [CLS_W-1:0]   class3;
  logic [PRED_W-1:0]  pred3;
  logic [FRAME_W-1:0] px_left, px_right, px_top, px_bottom;

  logic rdy_out, rdy3, rdy2, rdy1;
  logic step1;
  logic keep;

  logic [SCORE_W-1:0] score_in;
  logic               better;
  logic [SCORE_W-1:0] upd_score;
  logic [CLS_W-1:0]   upd_class;

  // A stage moves when the one after it is empty or moving.
  assign rdy_out  = !m_tvalid || m_tready;
  assign rdy3     = !v3 || rdy_out;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign step1    = v1 && rdy2;

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCORE_THRESHOLD: cfg.score_threshold <= cfg_data[SCORE_W-1:0];
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data[FRAME_W-1:0];
        REG_PAD_X:           cfg.pad_x           <= cfg_data[PAD_W-1:0];
        REG_PAD_Y:           cfg.pad_y           <= cfg_data[PAD_W-1:0];
        REG_INVERSE_SCALE:   cfg.inverse_scale   <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1  <= s_tuser;
      last1 <= s_tlast;
      data1 <= s_tdata;
    end
  end

  // Argmax update. The first class always takes the slot; afterward only a
  // strictly greater score replaces it.
  assign score_in  = data1[4*COORD_W +: SCORE_W];
  assign better    = (class_counter == '0) || (score_in > best_score);
  assign upd_score = (!classes_full && better) ? score_in : best_score;
  assign upd_class = (!classes_full && better) ? class_counter : best_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cx       <= '0;
      held_cy       <= '0;
      held_w        <= '0;
      held_h        <= '0;
      best_score    <= '0;
      best_class    <= '0;
      class_counter <= '0;
      classes_full  <= 1'b0;
      pred_counter  <= '0;
    end else if (step1) begin
      if (cmd1 == CMD_BOX) begin
        held_cx       <= data1[0*COORD_W +: COORD_W];
        held_cy       <= data1[1*COORD_W +: COORD_W];
        held_w        <= data1[2*COORD_W +: COORD_W];
        held_h        <= data1[3*COORD_W +: COORD_W];
        best_score    <= '0;
        best_class    <= '0;
        class_counter <= '0;
        classes_full  <= 1'b0;
      end else if (last1) begin
        best_score    <= '0;
        best_class    <= '0;
        class_counter <= '0;
        classes_full  <= 1'b0;
        if (pred_counter == PRED_W'(MAX_PREDICTIONS - 1)) begin
          pred_counter <= '0;
        end else begin
          pred_counter <= pred_counter + 1'b1;
        end
      end else begin
        best_score <= upd_score;
        best_class <= upd_class;
        if (!classes_full) begin
          if (class_counter == CLS_W'(MAX_CLASSES - 1)) begin
            classes_full <= 1'b1;
          end else begin
            class_counter <= class_counter + 1'b1;
          end
        end
      end
    end
  end

  // Stage 2: only a flagged score item goes on.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1 && (cmd1 == CMD_SCORE) && last1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      score2   <= upd_score;
      class2   <= upd_class;
      pred2    <= pred_counter;
      e_left   <= (EDGE_W'(held_cx) <<< 1) - EDGE_W'(held_w)
                  - $signed({3'b000, cfg.pad_x, 5'b00000});
      e_right  <= (EDGE_W'(held_cx) <<< 1) + EDGE_W'(held_w)
                  - $signed({3'b000, cfg.pad_x, 5'b00000});
      e_top    <= (EDGE_W'(held_cy) <<< 1) - EDGE_W'(held_h)
                  - $signed({3'b000, cfg.pad_y, 5'b00000});
      e_bottom <= (EDGE_W'(held_cy) <<< 1) + EDGE_W'(held_h)
                  - $signed({3'b000, cfg.pad_y, 5'b00000});
    end
  end

  // Stage 3.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      score3 <= score2;
      class3 <= class2;
      pred3  <= pred2;
    end
  end

  dhbd_edge u_left (
    .clk       (clk),
    .en        (rdy3),
    .edge_sub  (e_left),
    .inv_scale (cfg.inverse_scale),
    .round_up  (1'b0),
    .limit     (cfg.frame_width),
    .px        (px_left)
  );

  dhbd_edge u_right (
    .clk       (clk),
    .en        (rdy3),
    .edge_sub  (e_right),
    .inv_scale (cfg.inverse_scale),
    .round_up  (1'b1),
    .limit     (cfg.frame_width),
    .px        (px_right)
  );

  dhbd_edge u_top (
    .clk       (clk),
    .en        (rdy3),
    .edge_sub  (e_top),
    .inv_scale (cfg.inverse_scale),
    .round_up  (1'b0),
    .limit     (cfg.frame_height),
    .px        (px_top)
  );

  dhbd_edge u_bottom (
    .clk       (clk),
    .en        (rdy3),
    .edge_sub  (e_bottom),
    .inv_scale (cfg.inverse_scale),
    .round_up  (1'b1),
    .limit     (cfg.frame_height),
    .px        (px_bottom)
  );

  // Output register: weak or empty boxes are dropped here.
  assign keep = (score3 >= cfg.score_threshold) && (px_right > px_left)
                && (px_bottom > px_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_out) begin
      m_tvalid <= v3 && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      m_tdata <= OUT_DATA_W'({px_bottom, px_right, px_top, px_left, score3,
                              CLASS_ID_W'(class3), PRED_ID_W'(pred3)});
    end
  end

  // Checks.
  a_out_meets_threshold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[PRED_ID_W+CLASS_ID_W +: SCORE_W] >= cfg.score_threshold))
    else $error("result below score threshold");

  a_out_box_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[PRED_ID_W+CLASS_ID_W+SCORE_W+2*FRAME_W +: FRAME_W]
                  > m_tdata[PRED_ID_W+CLASS_ID_W+SCORE_W +: FRAME_W]))
    else $error("empty box delivered");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v3))
    else $error("result without a finished prediction");

  a_full_saturates: assert property (@(posedge clk) disable iff (rst)
    classes_full |-> (class_counter == CLS_W'(MAX_CLASSES - 1)))
    else $error("class counter moved past its limit");

endmodule

`default_nettype wire

// ===== verif/tb_detection_head_box_decode.sv =====
// Testbench for detection_head_box_decode: streams box and class-score requests,
// predicts every detection from its own copy of the decoder state and checks
// each result field. Depends on dhbd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_detection_head_box_decode;
  import dhbd_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;
  localparam longint PIXEL_ONE = longint'(1) << FRAC_SHIFT;

  typedef struct packed {
    logic               cmd;
    logic               last;
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] box_h;
    logic [COORD_W-1:0] box_w;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] center_x;
  } head_item_t;

  // Same bit order as m_tdata, prediction index in the lowest bits.
  typedef struct packed {
    logic [FRAME_W-1:0]    bottom;
    logic [FRAME_W-1:0]    right;
    logic [FRAME_W-1:0]    top;
    logic [FRAME_W-1:0]    left;
    logic [SCORE_W-1:0]    confidence;
    logic [CLASS_ID_W-1:0] class_id;
    logic [PRED_ID_W-1:0]  pred_index;
  } detection_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Predicted decoder state.
  cfg_t                  setup = CFG_RESET;
  int                    held_cx, held_cy, held_w, held_h;
  logic [SCORE_W-1:0]    best_score = '0;
  logic [CLASS_ID_W-1:0] best_class = '0;
  int                    class_count = 0;
  bit                    classes_full = 1'b0;
  logic [PRED_ID_W-1:0]  pred_index = '0;

  detection_t detections_due[$];
  detection_t want, got;
  int fail_count = 0;
  int items_sent = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  detection_head_box_decode i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Edge in 1/32 model pixel, times the Q4.16 inverse scale: 2^-21 source pixel.
  function automatic longint scaled_edge(int center, int size, int pad);
    longint e;
    e = 2 * longint'(center) + longint'(size) - 32 * longint'(pad);
    return e * longint'(setup.inverse_scale);
  endfunction

  function automatic logic [FRAME_W-1:0] clamp_px(longint v, logic [FRAME_W-1:0] limit);
    if (v < 0) begin
      return '0;
    end else if (v > longint'(limit)) begin
      return limit;
    end
    return FRAME_W'(v);
  endfunction

  function automatic void restart_argmax();
    best_score = '0;
    best_class = '0;
    class_count = 0;
    classes_full = 1'b0;
  endfunction

  task automatic predict_detection(head_item_t it);
    detection_t d;
    bit keep;
    if (it.cmd == CMD_BOX) begin
      held_cx = $signed(it.center_x);
      held_cy = $signed(it.center_y);
      held_w  = $signed(it.box_w);
      held_h  = $signed(it.box_h);
      restart_argmax();
    end else begin
      if (!classes_full) begin
        if (class_count == 0 || it.score > best_score) begin
          best_score = it.score;
          best_class = CLASS_ID_W'(class_count);
        end
        class_count++;
        if (class_count >= MAX_CLASSES) begin
          class_count = MAX_CLASSES - 1;
          classes_full = 1'b1;
        end
      end
      if (it.last) begin
        // Arithmetic shift floors; adding one pixel less a step first ceils.
        d.left   = clamp_px(scaled_edge(held_cx, -held_w, setup.pad_x) >>> FRAC_SHIFT,
                            setup.frame_width);
        d.right  = clamp_px((scaled_edge(held_cx, held_w, setup.pad_x) + PIXEL_ONE - 1)
                            >>> FRAC_SHIFT, setup.frame_width);
        d.top    = clamp_px(scaled_edge(held_cy, -held_h, setup.pad_y) >>> FRAC_SHIFT,
                            setup.frame_height);
        d.bottom = clamp_px((scaled_edge(held_cy, held_h, setup.pad_y) + PIXEL_ONE - 1)
                            >>> FRAC_SHIFT, setup.frame_height);
        d.pred_index = pred_index;
        d.class_id   = best_class;
        d.confidence = best_score;
        keep = best_score >= setup.score_threshold && d.right > d.left && d.bottom > d.top;
        if (keep) begin
          detections_due.insert(detections_due.size(), d);
        end
        if (pred_index == PRED_ID_W'(MAX_PREDICTIONS - 1)) begin
          pred_index = '0;
        end else begin
          pred_index = pred_index + 1'b1;
        end
        restart_argmax();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic head_item_t box_item(int cx, int cy, int w, int h);
    head_item_t it;
    it.cmd      = CMD_BOX;
    it.last     = 1'($urandom_range(1));
    it.score    = SCORE_W'($urandom);
    it.center_x = COORD_W'(cx);
    it.center_y = COORD_W'(cy);
    it.box_w    = COORD_W'(w);
    it.box_h    = COORD_W'(h);
    return it;
  endfunction

  function automatic head_item_t score_item(int score, bit last);
    head_item_t it;
    it.cmd      = CMD_SCORE;
    it.last     = last;
    it.score    = SCORE_W'(score);
    it.center_x = COORD_W'($urandom);
    it.center_y = COORD_W'($urandom);
    it.box_w    = COORD_W'($urandom);
    it.box_h    = COORD_W'($urandom);
    return it;
  endfunction

  function automatic head_item_t random_box();
    if ($urandom_range(4) == 0) begin
      return box_item($urandom, $urandom, $urandom, $urandom);
    end
    return box_item($urandom_range(640 * 16), $urandom_range(640 * 16),
                    $urandom_range(1, 320 * 16), $urandom_range(1, 320 * 16));
  endfunction

  // Ties with the previous score are frequent so the first-wins rule is hit.
  function automatic int next_score(int prev);
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      return prev;
    end else if (r < 25) begin
      return 0;
    end else if (r < 30) begin
      return 65535;
    end
    return $urandom_range(65535);
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_item(head_item_t it);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tlast  <= it.last;
    s_tdata  <= {it.score, it.box_h, it.box_w, it.center_y, it.center_x};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_detection(it);
  endtask

  task automatic send_scores(int n, bit close);
    int prev;
    prev = $urandom_range(65535);
    for (int k = 0; k < n; k++) begin
      prev = next_score(prev);
      send_item(score_item(prev, close && k == n - 1));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (detections_due.size() != 0) @(posedge clk);
    // A dropped prediction leaves no trace, so give the pipeline time to empty.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCORE_THRESHOLD: setup.score_threshold = SCORE_W'(value);
      REG_FRAME_WIDTH:     setup.frame_width     = FRAME_W'(value);
      REG_FRAME_HEIGHT:    setup.frame_height    = FRAME_W'(value);
      REG_PAD_X:           setup.pad_x           = PAD_W'(value);
      REG_PAD_Y:           setup.pad_y           = PAD_W'(value);
      REG_INVERSE_SCALE:   setup.inverse_scale   = INV_W'(value);
      default: ;
    endcase
  endtask

  task automatic write_setup(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] fw,
                             logic [CFG_DATA_W-1:0] fh, logic [CFG_DATA_W-1:0] px,
                             logic [CFG_DATA_W-1:0] py, logic [CFG_DATA_W-1:0] inv);
    write_reg(REG_SCORE_THRESHOLD, thr);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_PAD_X, px);
    write_reg(REG_PAD_Y, py);
    write_reg(REG_INVERSE_SCALE, inv);
  endtask

  task automatic randomize_setup();
    int thr, fw, fh, px, py, inv;
    thr = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40000);
    fw  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 4096);
    fh  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 4096);
    px  = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(160);
    py  = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(160);
    inv = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1 << 15, 1 << 18);
    write_setup(CFG_DATA_W'(thr), CFG_DATA_W'(fw), CFG_DATA_W'(fh),
                CFG_DATA_W'(px), CFG_DATA_W'(py), CFG_DATA_W'(inv));
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    m_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_BITS-1:0];
      if (detections_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected detection: idx %0d cls %0d conf %h box %0d %0d %0d %0d",
                   got.pred_index, got.class_id, got.confidence,
                   got.left, got.top, got.right, got.bottom);
        end
      end else begin
        want = detections_due.pop_front();
        if (got.pred_index != want.pred_index || got.class_id != want.class_id ||
            got.confidence != want.confidence || got.left != want.left ||
            got.top != want.top || got.right != want.right ||
            got.bottom != want.bottom) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("detection mismatch: expected idx %0d cls %0d conf %h box %0d %0d %0d %0d",
                     want.pred_index, want.class_id, want.confidence,
                     want.left, want.top, want.right, want.bottom);
            $display("                    actual   idx %0d cls %0d conf %h box %0d %0d %0d %0d",
                     got.pred_index, got.class_id, got.confidence,
                     got.left, got.top, got.right, got.bottom);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: a tie on the best score, then score-only predictions
  // just under and exactly at the threshold.
  task automatic test_default_setup();
    send_item(box_item(320 * 16, 280 * 16, 100 * 16, 80 * 16));
    send_item(score_item(16'h3000, 1'b0));
    send_item(score_item(16'h7000, 1'b0));
    send_item(score_item(16'h7000, 1'b1));
    send_item(score_item(16'h3FFF, 1'b1));
    send_item(score_item(16'h4000, 1'b1));
  endtask

  task automatic test_register_extremes();
    write_setup(0, 4096, 4096, 0, 0, 20'hFFFFF);
    send_item(box_item(0, 0, 32767, 32767));
    send_item(score_item(0, 1'b1));
    send_item(box_item(32767, -32768, -32768, 32767));
    send_item(score_item(65535, 1'b1));
    write_setup(65535, 1, 1, 2047, 2047, 1);
    send_item(box_item(32767, 32767, 16, 16));
    send_item(score_item(65535, 1'b1));
    send_item(score_item(65534, 1'b1));
    // Data wider than every register but the inverse scale: the upper bits are masked off.
    write_setup(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_item(box_item(32767, 32767, 32767, 32767));
    send_item(score_item(65535, 1'b1));
  endtask

  task automatic test_special_cases();
    head_item_t it;
    int sc;
    write_setup(8192, 1280, 720, 0, 80, 131072);
    // A new box in the middle of a prediction discards its scores.
    send_item(box_item(200 * 16, 150 * 16, 40 * 16, 30 * 16));
    send_item(score_item(16'h9000, 1'b0));
    send_item(box_item(600 * 16, 400 * 16, 64 * 16, 64 * 16));
    send_item(score_item(16'h2100, 1'b0));
    send_item(score_item(16'h2100, 1'b1));
    // Scores without a box start a prediction on the held box.
    send_item(score_item(16'h1000, 1'b0));
    send_item(score_item(16'h8000, 1'b1));
    // Negative width gives an empty box.
    send_item(box_item(300 * 16, 300 * 16, -50 * 16, 40 * 16));
    send_item(score_item(16'hFFFF, 1'b1));
    // Scores past the last class slot must not move the argmax.
    it = box_item(500 * 16, 300 * 16, 80 * 16, 60 * 16);
    it.last = 1'b1;
    send_item(it);
    for (int k = 0; k < MAX_CLASSES + 2; k++) begin
      if (k == MAX_CLASSES - 1) begin
        sc = 16'hF000;
      end else if (k >= MAX_CLASSES) begin
        sc = 16'hFFFF;
      end else begin
        sc = 16'h1000;
      end
      send_item(score_item(sc, k == MAX_CLASSES + 1));
    end
    // Zero frame sizes and a zero scale collapse every box.
    write_reg(REG_FRAME_WIDTH, 0);
    send_item(score_item(16'hFFFF, 1'b1));
    write_reg(REG_FRAME_WIDTH, 1280);
    write_reg(REG_FRAME_HEIGHT, 0);
    send_item(score_item(16'hFFFF, 1'b1));
    write_reg(REG_FRAME_HEIGHT, 720);
    write_reg(REG_INVERSE_SCALE, 0);
    send_item(score_item(16'hFFFF, 1'b1));
    write_reg(REG_INVERSE_SCALE, 131072);
    send_item(score_item(16'hFFFF, 1'b1));
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
    int start;
    int kind;
    int n;
    bit reconfigured;
    start = items_sent;
    reconfigured = 1'b0;
    randomize_setup();
    send_idle = idle_pct;
    recv_stall = stall_pct;
    while (items_sent - start < n_items) begin
      if (!reconfigured && items_sent - start >= n_items / 2) begin
        randomize_setup();
        reconfigured = 1'b1;
      end
      kind = $urandom_range(99);
      n = ($urandom_range(59) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 8);
      if (kind < 85) begin
        send_item(random_box());
        send_scores(n, 1'b1);
      end else if (kind < 92) begin
        send_scores(n, 1'b1);
      end else if (kind < 97) begin
        send_item(random_box());
        send_scores($urandom_range(1, 4), 1'b0);
        send_item(random_box());
        send_scores(n, 1'b1);
      end else if ($urandom_range(1) == 0) begin
        send_item(random_box());
      end else begin
        send_item(score_item(int'($urandom_range(65535)), 1'($urandom_range(1))));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_default_setup();
    test_register_extremes();
    test_special_cases();
    test_random_traffic(0, 0, 400);
    test_random_traffic(76, 0, 400);
    test_random_traffic(0, 76, 400);
    test_random_traffic(36, 36, 400);
    wait_drained();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
